/* src/lfc_pkg.sv */
// ----------------------------------------------------------------------------
// lfc_pkg
// Types and constants shared by the forward correction block and its checker.
// ----------------------------------------------------------------------------
package lfc_pkg;

  localparam int DIST_W = 16;
  localparam int AMP_W  = 16;
  localparam int COS_W  = 15;
  localparam int POS_W  = 32;
  localparam int LIM_W  = 20;
  localparam int CFG_W  = 20;
  localparam int CIDX_W = 3;
  localparam int SUM_W  = 32;

  // Serial multiplier: distance times the non-negative cosine.
  localparam int PROD_W    = DIST_W + COS_W;
  localparam int MUL_CNT_W = $clog2(COS_W);
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(COS_W - 1);

  // Serial divider by a small constant (25, or the baseline sample count).
  localparam int QUO_W     = 32;
  localparam int DIV_W     = 7;
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);
  localparam logic [DIV_W-1:0]     PROJ_DIV = 7'd25;

  localparam logic [AMP_W-1:0] AMP_SAT = 16'hFFFF;

  localparam logic [DIST_W-1:0] MIN_DIST_RST = 16'd20;
  localparam logic [DIST_W-1:0] MAX_DIST_RST = 16'd800;
  localparam logic [AMP_W-1:0]  MIN_AMP_RST  = 16'd100;
  localparam logic [COS_W-1:0]  MIN_COS_RST  = 15'd11469;
  localparam logic [LIM_W-1:0]  MAX_DIS_RST  = 20'd22938;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MIN_DIST = 3'd0,
    CFG_MAX_DIST = 3'd1,
    CFG_MIN_AMP  = 3'd2,
    CFG_MIN_COS  = 3'd3,
    CFG_MAX_DIS  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_RESET    = 3'd0,
    ST_READFAIL = 3'd1,
    ST_RANGE    = 3'd2,
    ST_COSINE   = 3'd3,
    ST_ACCUM    = 3'd4,
    ST_DONE     = 3'd5,
    ST_FUSED    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_PROJ,
    S_AVG,
    S_DIFF,
    S_TGT,
    S_OUT
  } state_t;

endpackage

/* src/lfc_smul.sv */
// ----------------------------------------------------------------------------
// lfc_smul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lfc_smul import lfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIST_W-1:0] a_in,
  input  logic [COS_W-1:0]  b_in,
  output logic              done,
  output logic [PROD_W-1:0] product
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [DIST_W-1:0]    a;
  logic [DIST_W:0]      step_sum;

  // The upper half collects partial sums while the multiplier shifts out below.
  assign step_sum = {1'b0, product[PROD_W-1:COS_W]} + (product[0] ? {1'b0, a} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == MUL_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a       <= a_in;
      product <= {{DIST_W{1'b0}}, b_in};
    end else if (busy) begin
      product <= {step_sum, product[COS_W-1:1]};
    end
  end

endmodule

/* src/lfc_sdiv.sv */
// ----------------------------------------------------------------------------
// lfc_sdiv
// Restoring divider by a small divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfc_sdiv import lfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [QUO_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     trial;
  logic                 ge;

  // The remainder stays below the divisor, so its top bit is clear for a divisor of at most 64.
  assign trial = {rem[DIV_W-2:0], quotient[QUO_W-1]};
  assign ge    = (trial >= dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= ge ? (trial - dvs) : trial;
      quotient <= {quotient[QUO_W-2:0], ge};
    end
  end

endmodule

/* src/lidar_forward_correction.sv */
// ----------------------------------------------------------------------------
// lidar_forward_correction
// Gathers a still baseline of projected rangefinder distances, then turns each
// good reading into a clamped forward position target.
// ----------------------------------------------------------------------------
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-----------------------------------
//  input    | in_valid / in_stall            | read_ok, is_stationary, range_cm,
//           |                                | amplitude, forward_cos, position_now
//  output   | out_valid / out_stall          | fused, target_position, status
//  config   | cfg_write, cfg_index, cfg_data | five threshold registers
//
// A rejected reading goes from S_CHECK to S_OUT and loads the output register
// once it is free. A good reading takes the serial multiply and the serial
// divide by 25, then goes to S_OUT while the baseline builds, or through S_DIFF
// and S_TGT once it is complete. The reading that completes the baseline also
// takes the serial divide by BASELINE_SAMPLES. One word is worked at a time,
// and the next word is accepted the cycle after the output register loads.
// The output register lets the next word enter while a result waits; a second
// finished word waits inside, with the input stalled, until it is taken.
// Reset is synchronous and clears the baseline and the thresholds to defaults.
// ----------------------------------------------------------------------------
module lidar_forward_correction import lfc_pkg::*; #(
  parameter int BASELINE_SAMPLES = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     read_ok,
  input  logic                     is_stationary,
  input  logic [DIST_W-1:0]        range_cm,
  input  logic [AMP_W-1:0]         amplitude,
  input  logic signed [15:0]       forward_cos,
  input  logic signed [POS_W-1:0]  position_now,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     fused,
  output logic signed [POS_W-1:0]  target_position,
  output logic [2:0]               status
);

  localparam int CNT_W = $clog2(BASELINE_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BASELINE_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BASELINE_SAMPLES - 1);
  localparam logic [DIV_W-1:0] NSAMP    = DIV_W'(BASELINE_SAMPLES);

  state_t state, state_next;

  logic [DIST_W-1:0] min_dist, max_dist;
  logic [AMP_W-1:0]  min_amp;
  logic [COS_W-1:0]  min_cos;
  logic [LIM_W-1:0]  max_dis;

  logic [SUM_W-1:0]  baseline_sum;
  logic [CNT_W-1:0]  baseline_count;

  logic                    item_ok, item_still;
  logic [DIST_W-1:0]       item_dist;
  logic [AMP_W-1:0]        item_amp;
  logic [15:0]             item_cos;
  logic signed [POS_W-1:0] item_pos;

  logic                    res_fused;
  logic [POS_W-1:0]        res_target;
  status_t                 res_status;

  logic signed [SUM_W+1:0] d;
  logic                    over, under;

  logic                    mul_start, mul_done;
  logic [PROD_W-1:0]       mul_prod;
  logic                    div_start, div_done;
  logic [QUO_W-1:0]        div_dividend, div_quo;
  logic [DIV_W-1:0]        div_divisor;

  logic                    incomplete, range_bad, cos_bad, out_free;
  logic [SUM_W:0]          sum_wide;
  logic [SUM_W-1:0]        sum_sat;
  logic signed [SUM_W+1:0] d_next;
  logic signed [SUM_W+2:0] diff, lim_w, pos_w, tgt_w;
  logic [POS_W-1:0]        tgt_sat;

  assign in_stall   = (state != S_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign incomplete = (baseline_count < CNT_FULL);

  assign range_bad = (item_dist < min_dist) || (item_dist > max_dist) ||
                     (item_amp < min_amp) || (item_amp == AMP_SAT);
  // Any negative cosine fails, since the minimum is never negative.
  assign cos_bad   = item_cos[15] || (item_cos[COS_W-1:0] < min_cos);

  assign sum_wide = {1'b0, baseline_sum} + {1'b0, div_quo};
  assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  assign d_next   = $signed({2'b00, baseline_sum}) - $signed({2'b00, div_quo});

  assign pos_w = {{3{item_pos[POS_W-1]}}, item_pos};
  assign lim_w = $signed({{(SUM_W+3-LIM_W){1'b0}}, max_dis});
  assign diff  = {d[SUM_W+1], d} - pos_w;

  always_comb begin
    if (over) begin
      tgt_w = pos_w + lim_w;
    end else if (under) begin
      tgt_w = pos_w - lim_w;
    end else begin
      tgt_w = {d[SUM_W+1], d};
    end
  end

  // Saturate to the signed 32-bit range when the top bits disagree.
  always_comb begin
    if (tgt_w[SUM_W+2:POS_W-1] == '0 || tgt_w[SUM_W+2:POS_W-1] == '1) begin
      tgt_sat = tgt_w[POS_W-1:0];
    end else if (tgt_w[SUM_W+2]) begin
      tgt_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      tgt_sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_next   = state;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = sum_sat;
    div_divisor  = NSAMP;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if ((incomplete && !item_still) || !item_ok || range_bad || cos_bad) begin
          state_next = S_OUT;
        end else begin
          mul_start  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        div_dividend = {{(QUO_W-PROD_W){1'b0}}, mul_prod};
        div_divisor  = PROJ_DIV;
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = S_PROJ;
        end
      end
      S_PROJ: begin
        if (div_done) begin
          if (!incomplete) begin
            state_next = S_DIFF;
          end else if (baseline_count == CNT_LAST) begin
            div_start  = 1'b1;
            state_next = S_AVG;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_AVG: begin
        if (div_done) state_next = S_OUT;
      end
      S_DIFF:  state_next = S_TGT;
      S_TGT:   state_next = S_OUT;
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist <= MIN_DIST_RST;
      max_dist <= MAX_DIST_RST;
      min_amp  <= MIN_AMP_RST;
      min_cos  <= MIN_COS_RST;
      max_dis  <= MAX_DIS_RST;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_DIST: min_dist <= cfg_data[DIST_W-1:0];
        CFG_MAX_DIST: max_dist <= cfg_data[DIST_W-1:0];
        CFG_MIN_AMP:  min_amp  <= cfg_data[AMP_W-1:0];
        CFG_MIN_COS:  min_cos  <= cfg_data[COS_W-1:0];
        CFG_MAX_DIS:  max_dis  <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_sum   <= '0;
      baseline_count <= '0;
    end else if (state == S_CHECK && incomplete && !item_still) begin
      baseline_sum   <= '0;
      baseline_count <= '0;
    end else if (state == S_PROJ && div_done && incomplete) begin
      baseline_sum   <= sum_sat;
      baseline_count <= baseline_count + 1'b1;
    end else if (state == S_AVG && div_done) begin
      baseline_sum   <= div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item_ok    <= read_ok;
      item_still <= is_stationary;
      item_dist  <= range_cm;
      item_amp   <= amplitude;
      item_cos   <= forward_cos;
      item_pos   <= position_now;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_CHECK: begin
        res_fused  <= 1'b0;
        res_target <= '0;
        if (incomplete && !item_still) begin
          res_status <= ST_RESET;
        end else if (!item_ok) begin
          res_status <= ST_READFAIL;
        end else if (range_bad) begin
          res_status <= ST_RANGE;
        end else begin
          res_status <= cos_bad ? ST_COSINE : ST_ACCUM;
        end
      end
      S_PROJ: begin
        d <= d_next;
      end
      S_AVG: begin
        res_status <= ST_DONE;
      end
      S_DIFF: begin
        over  <= (diff > lim_w);
        under <= (diff < -lim_w);
      end
      S_TGT: begin
        res_fused  <= 1'b1;
        res_target <= tgt_sat;
        res_status <= ST_FUSED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      fused           <= res_fused;
      target_position <= res_target;
      status          <= res_status;
    end
  end

  lfc_smul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a_in    (item_dist),
    .b_in    (item_cos[COS_W-1:0]),
    .done    (mul_done),
    .product (mul_prod)
  );

  lfc_sdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

/* src/lfc_checker.sv */
// ----------------------------------------------------------------------------
// lfc_checker
// Port-level checks on the forward correction block, bound to its top level.
// ----------------------------------------------------------------------------
module lfc_checker import lfc_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    fused,
  input logic signed [POS_W-1:0] target_position,
  input logic [2:0]              status
);

  // A target is flagged exactly when the status says the reading was fused.
  a_fused_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fused == (status == ST_FUSED)))
    else $error("fused flag disagrees with status");

  // Words that carry no target carry a zero position.
  a_zero_target: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !fused) |-> (target_position == '0))
    else $error("nonzero target on an unfused word");

  // An accepted word passes S_CHECK and then S_OUT before the output register
  // loads, so it cannot produce a fresh result straight after acceptance.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_valid) |=> !out_valid)
    else $error("result appeared one cycle after acceptance");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(target_position) && $stable(status) && $stable(fused)))
    else $error("stalled output word changed");

endmodule

bind lidar_forward_correction lfc_checker u_lfc_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Forward correction block testbench
// Sends rangefinder readings with random handshake gaps and compares every
// result word with an internal predictor. The predictor follows the baseline
// gathering and the clamped target math. The run goes through several
// threshold settings, and the extreme settings are among them.
// ----------------------------------------------------------------------------

typedef struct {
  bit               read_ok;
  bit               still;
  bit [15:0]        range_cm;
  bit [15:0]        amp;
  bit signed [15:0] cosine;
  bit signed [31:0] pos;
} reading_t;

typedef struct {
  bit                fused;
  bit signed [31:0]  target;
  lfc_pkg::status_t  status;
} correction_t;

class correction_scoreboard;
  bit [15:0]   min_dist;
  bit [15:0]   max_dist;
  bit [15:0]   min_amp;
  bit [14:0]   min_cos;
  bit [19:0]   max_dis;
  bit [31:0]   base_sum;
  int unsigned base_count;
  int unsigned samples;
  int          errors;
  correction_t expected_q[$];

  function new(int unsigned n);
    samples    = n;
    min_dist   = lfc_pkg::MIN_DIST_RST;
    max_dist   = lfc_pkg::MAX_DIST_RST;
    min_amp    = lfc_pkg::MIN_AMP_RST;
    min_cos    = lfc_pkg::MIN_COS_RST;
    max_dis    = lfc_pkg::MAX_DIS_RST;
    base_sum   = '0;
    base_count = 0;
    errors     = 0;
  endfunction

  function void set_reg(lfc_pkg::cfg_idx_t idx, bit [19:0] data);
    case (idx)
      lfc_pkg::CFG_MIN_DIST: min_dist = data[15:0];
      lfc_pkg::CFG_MAX_DIST: max_dist = data[15:0];
      lfc_pkg::CFG_MIN_AMP:  min_amp  = data[15:0];
      lfc_pkg::CFG_MIN_COS:  min_cos  = data[14:0];
      lfc_pkg::CFG_MAX_DIS:  max_dis  = data;
      default: ;
    endcase
  endfunction

  // Distance in cm times a Q2.14 cosine over 25 gives Q16.16 metres.
  function bit [31:0] projected(bit [15:0] range_cm, int cosv);
    longint unsigned d;
    longint unsigned c;
    longint unsigned p;
    d = range_cm;
    c = cosv;
    p = (d * c) / 25;
    return p[31:0];
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_reading(reading_t r);
    correction_t     e;
    int              cosv;
    bit [31:0]       proj;
    longint unsigned total;
    longint          diff;
    longint          lim;
    longint          tgt;
    e    = '{1'b0, 32'sd0, lfc_pkg::ST_FUSED};
    cosv = r.cosine;
    if (base_count < samples && !r.still) begin
      base_sum   = '0;
      base_count = 0;
      e.status   = lfc_pkg::ST_RESET;
    end else if (!r.read_ok) begin
      e.status = lfc_pkg::ST_READFAIL;
    end else if (r.range_cm < min_dist || r.range_cm > max_dist || r.amp < min_amp ||
                 r.amp == lfc_pkg::AMP_SAT) begin
      e.status = lfc_pkg::ST_RANGE;
    end else if (cosv < int'(min_cos)) begin
      e.status = lfc_pkg::ST_COSINE;
    end else begin
      proj = projected(r.range_cm, cosv);
      if (base_count < samples) begin
        total    = {32'b0, base_sum} + {32'b0, proj};
        base_sum = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        base_count++;
        if (base_count == samples) begin
          base_sum = base_sum / samples;
          e.status = lfc_pkg::ST_DONE;
        end else begin
          e.status = lfc_pkg::ST_ACCUM;
        end
      end else begin
        lim  = longint'({44'b0, max_dis});
        diff = longint'({32'b0, base_sum}) - longint'({32'b0, proj}) - longint'(r.pos);
        if (diff > lim) diff = lim;
        if (diff < -lim) diff = -lim;
        tgt = longint'(r.pos) + diff;
        if (tgt > 64'sh7FFF_FFFF) tgt = 64'sh7FFF_FFFF;
        if (tgt < -64'sh8000_0000) tgt = -64'sh8000_0000;
        e.fused  = 1'b1;
        e.target = tgt[31:0];
      end
    end
    expected_q.push_back(e);
  endfunction

  function void check_result(logic f, logic signed [31:0] t, logic [2:0] s);
    correction_t e;
    if (expected_q.size() == 0) begin
      $error("result word with no reading pending: fused %0d target %0d status %0d",
             f, t, s);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (f !== e.fused) begin
      $error("fused: expected %0d, got %0d", e.fused, f);
      errors++;
    end
    if (t !== e.target) begin
      $error("target_position: expected %0d, got %0d", e.target, t);
      errors++;
    end
    if (s !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, s);
      errors++;
    end
  endfunction
endclass

module testbench;
  import lfc_pkg::*;

  localparam int SAMPLES      = 8;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_TIME  = 100;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  cfg_idx_t                cfg_index = CFG_MIN_DIST;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    read_ok = 1'b0;
  logic                    is_stationary = 1'b0;
  logic [DIST_W-1:0]       range_cm = '0;
  logic [AMP_W-1:0]        amplitude = '0;
  logic signed [15:0]      forward_cos = '0;
  logic signed [POS_W-1:0] position_now = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    fused;
  logic signed [POS_W-1:0] target_position;
  logic [2:0]              status;

  correction_scoreboard sb;
  int                   gap_max = 0;
  int                   stall_max = 0;
  int unsigned          cycle_count = 0;

  lidar_forward_correction #(.BASELINE_SAMPLES(SAMPLES)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .read_ok(read_ok), .is_stationary(is_stationary), .range_cm(range_cm),
    .amplitude(amplitude), .forward_cos(forward_cos), .position_now(position_now),
    .out_valid(out_valid), .out_stall(out_stall),
    .fused(fused), .target_position(target_position), .status(status)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic reading_t mk(bit ok, bit still, bit [15:0] d, bit [15:0] a,
                                  bit signed [15:0] c, bit signed [31:0] p);
    reading_t r;
    r = '{ok, still, d, a, c, p};
    return r;
  endfunction

  // Position that makes the disagreement come out as off before clamping.
  function automatic bit signed [31:0] aim_position(reading_t r, int off);
    longint p;
    p = longint'({32'b0, sb.base_sum}) -
        longint'({32'b0, sb.projected(r.range_cm, r.cosine)}) - longint'(off);
    return p[31:0];
  endfunction

  function automatic bit [15:0] pick16(bit [15:0] lo, bit [15:0] hi);
    if (lo > hi) return 16'($urandom);
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic reading_t good_reading();
    reading_t r;
    int       lim;
    int       span;
    r.read_ok  = 1'b1;
    r.still    = (sb.base_count < SAMPLES) ? 1'b1 : 1'($urandom);
    r.range_cm = pick16(sb.min_dist, sb.max_dist);
    r.amp      = pick16(sb.min_amp, AMP_SAT - 16'd1);
    r.cosine   = pick16({1'b0, sb.min_cos}, 16'h7FFF);
    r.pos      = $urandom;
    if (sb.base_count >= SAMPLES) begin
      lim  = int'(sb.max_dis);
      span = lim + 16;
      case ($urandom_range(0, 9))
        0:       r.pos = $urandom;
        1:       r.pos = aim_position(r, lim);
        2:       r.pos = aim_position(r, -lim);
        3:       r.pos = aim_position(r, lim + 1);
        4:       r.pos = aim_position(r, -lim - 1);
        default: r.pos = aim_position(r, int'($urandom_range(0, 2 * span)) - span);
      endcase
    end
    return r;
  endfunction

  // A good reading with one field changed, mostly to a value that fails a check.
  function automatic reading_t broken_reading();
    reading_t r;
    r = good_reading();
    case ($urandom_range(0, 8))
      0: r.read_ok  = 1'b0;
      1: r.still    = 1'b0;
      2: r.range_cm = sb.min_dist - 16'd1;
      3: r.range_cm = sb.max_dist + 16'd1;
      4: r.amp      = sb.min_amp - 16'd1;
      5: r.amp      = AMP_SAT;
      6: r.cosine   = $signed({1'b0, sb.min_cos}) - 16'sd1;
      7: r.cosine   = -16'($urandom_range(1, 16384));
      default: r.cosine = 16'sh8000;
    endcase
    return r;
  endfunction

  function automatic reading_t noise_reading();
    reading_t r;
    r = '{1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
          32'($urandom)};
    // Keep most noise still while the baseline builds so that it can finish.
    if (sb.base_count < SAMPLES && $urandom_range(0, 9) != 0) r.still = 1'b1;
    return r;
  endfunction

  task automatic send_reading(reading_t r);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    read_ok       <= r.read_ok;
    is_stationary <= r.still;
    range_cm      <= r.range_cm;
    amplitude     <= r.amp;
    forward_cos   <= r.cosine;
    position_now  <= r.pos;
    do @(posedge clk); while (in_stall);
    sb.note_reading(r);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Values go in register index order.
  task automatic apply_setting(bit [19:0] vals [5]);
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(cfg_idx_t'(i), vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic int pick_idle();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 8;
    endcase
  endfunction

  task automatic send_mixed();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) send_reading(good_reading());
    else if (pick < 85) send_reading(broken_reading());
    else send_reading(noise_reading());
  endtask

  task automatic run_random(int n);
    gap_max   = pick_idle();
    stall_max = pick_idle();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 59) == 0) wait_idle();
      send_mixed();
    end
  endtask

  task automatic random_setting();
    bit [15:0] lo;
    bit [15:0] hi;
    lo = $urandom_range(0, 1000);
    hi = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(lo, 4000));
    // The upper data bits above each register's width are junk on purpose.
    apply_setting('{{4'($urandom), lo}, {4'($urandom), hi},
                    {4'($urandom), 16'($urandom_range(0, 2000))},
                    {5'($urandom), 15'($urandom_range(0, 16384))},
                    20'($urandom_range(0, 655360))});
  endtask

  initial begin : result_sink
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = $urandom_range(0, stall_max);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(fused, target_position, status);
    end
  end

  initial begin : reading_source
    reading_t r;
    sb = new(SAMPLES);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values, empty baseline: every reject and the restart on motion.
    send_reading(mk(1'b0, 1'b0, 16'd400, 16'd1000, 16'sd16384, 32'sd0));
    send_reading(mk(1'b0, 1'b1, 16'd400, 16'd1000, 16'sd16384, 32'sd0));
    send_reading(mk(1'b1, 1'b1, MIN_DIST_RST - 16'd1, 16'd1000, 16'sd16384, 32'sd0));
    send_reading(mk(1'b1, 1'b1, MAX_DIST_RST + 16'd1, 16'd1000, 16'sd16384, 32'sd0));
    send_reading(mk(1'b1, 1'b1, 16'd400, MIN_AMP_RST - 16'd1, 16'sd16384, 32'sd0));
    send_reading(mk(1'b1, 1'b1, 16'd400, AMP_SAT, 16'sd16384, 32'sd0));
    send_reading(mk(1'b1, 1'b1, 16'd400, 16'd1000, $signed({1'b0, MIN_COS_RST}) - 16'sd1,
                    32'sd0));
    send_reading(mk(1'b1, 1'b1, 16'd400, 16'd1000, -16'sd16384, 32'sd0));
    send_reading(mk(1'b1, 1'b1, 16'd400, 16'd1000, 16'sh8000, 32'sd0));
    send_reading(mk(1'b1, 1'b1, MIN_DIST_RST, MIN_AMP_RST, $signed({1'b0, MIN_COS_RST}),
                    32'sh7FFF_FFFF));
    send_reading(mk(1'b1, 1'b1, MAX_DIST_RST, AMP_SAT - 16'd1, 16'sh7FFF, 32'sh8000_0000));
    send_reading(mk(1'b1, 1'b0, 16'd400, 16'd1000, 16'sd16384, 32'sd0));
    send_reading(mk(1'b1, 1'b1, 16'd300, 16'd500, 16'sd16384, 32'sd0));

    // The baseline completes under random traffic, then the target edges.
    gap_max   = 8;
    stall_max = 8;
    while (sb.base_count < SAMPLES) send_mixed();
    r = mk(1'b1, 1'b1, 16'd400, 16'd1000, 16'sd16384, 32'sd0);
    send_reading(r);
    r.pos = 32'sh7FFF_FFFF;
    send_reading(r);
    r.pos = 32'sh8000_0000;
    send_reading(r);
    r.pos = aim_position(r, int'(sb.max_dis));
    send_reading(r);
    r.pos = aim_position(r, -int'(sb.max_dis) - 1);
    send_reading(r);
    r.still = 1'b0;
    r.pos   = aim_position(r, 5);
    send_reading(r);
    r.read_ok = 1'b0;
    send_reading(r);
    run_random(150);

    apply_setting('{20'd0, 20'd65535, 20'd0, 20'd0, 20'd655360});
    run_random(120);
    apply_setting('{20'd500, 20'd500, 20'd65534, 20'd32767, 20'd0});
    run_random(40);
    apply_setting('{20'd900, 20'd100, 20'd65535, 20'd0, 20'hFFFFF});
    run_random(40);
    repeat (4) begin
      random_setting();
      run_random(120);
    end

    wait_idle();
    repeat (SETTLE_TIME) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

/* lidar_forward_correction.f */
src/lfc_pkg.sv
src/lfc_smul.sv
src/lfc_sdiv.sv
src/lidar_forward_correction.sv
src/lfc_checker.sv
test/testbench.sv
